/* design/dmifs_pkg.sv */
`timescale 1ns / 1ps

package dmifs_pkg;

    // grid and store geometry
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int COORD_W    = 6;
    localparam int ADDR_W     = 2 * COORD_W;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int DIM_W      = 7;

    // datapath widths
    localparam int SCALE_W = 48;
    localparam int MAG_W   = 16;
    localparam int VEC_W   = 3 * MAG_W;
    localparam int DIFF_W  = MAG_W + 1;
    localparam int MS_W    = 22;
    localparam int FIELD_W = 32;
    localparam int HALF_W  = SCALE_W / 2;
    localparam int PP_W    = HALF_W + MAG_W;
    localparam int ACC_W   = 66;
    localparam int NUM_W   = ACC_W - 1 - 15;
    localparam int CFG_IDX_W = 3;

    // sequencing
    localparam int CNT_W       = 6;
    localparam int NUM_READS   = 5;
    localparam int NUM_MUL_OPS = 8;
    localparam int DIV_STEPS   = FIELD_W;
    localparam int NUM_LANES   = 3;

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_COMPUTE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE_X     = 3'd0,
        CFG_SCALE_Y     = 3'd1,
        CFG_PERIODIC    = 3'd2,
        CFG_WIDTH_USED  = 3'd3,
        CFG_HEIGHT_USED = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        NB_CENTER = 3'd0,
        NB_UP     = 3'd1,
        NB_DOWN   = 3'd2,
        NB_LEFT   = 3'd3,
        NB_RIGHT  = 3'd4
    } nb_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_MULT,
        ST_DIVINIT,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        OUT_FIELD,
        OUT_ERROR,
        OUT_ZERO
    } out_kind_t;

    typedef struct packed {
        logic                     req_type;
        logic [COORD_W-1:0]       cell_x;
        logic [COORD_W-1:0]       cell_y;
        logic signed [MAG_W-1:0]  mag_x;
        logic signed [MAG_W-1:0]  mag_y;
        logic signed [MAG_W-1:0]  mag_z;
        logic [MS_W-1:0]          sat_mag;
    } req_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] field_x;
        logic signed [FIELD_W-1:0] field_y;
        logic signed [FIELD_W-1:0] field_z;
        logic                      saturated;
        logic                      coord_error;
    } rsp_t;

    typedef struct packed {
        logic      load_wr;
        logic      latch;
        logic      acc_clr;
        logic      rd_en;
        nb_t       rd_idx;
        logic      cap_en;
        nb_t       cap_idx;
        logic      mul_en;
        logic [2:0] mul_op;
        logic      div_init;
        logic      div_step;
        logic      out_load;
        out_kind_t out_kind;
    } cmd_t;

    typedef struct packed {
        logic coord_err;
        logic ms_zero;
    } sts_t;

endpackage

/* design/dmifs_ctrl.sv */
`timescale 1ns / 1ps

module dmifs_ctrl import dmifs_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  logic req_type,
    output logic rsp_valid,
    input  logic rsp_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    out_kind_t         kind_reg, kind_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic              slot_free;

    assign slot_free = !rsp_valid_reg || rsp_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        kind_next  = kind_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && req_type == REQ_COMPUTE)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cnt_next = '0;
                if (sts.coord_err)
                begin
                    state_next = ST_FINISH;
                    kind_next  = OUT_ERROR;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (cnt_reg == CNT_W'(NUM_READS))
                begin
                    cnt_next = '0;
                    if (sts.ms_zero)
                    begin
                        state_next = ST_FINISH;
                        kind_next  = OUT_ZERO;
                    end
                    else
                    begin
                        state_next = ST_MULT;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MULT:
            begin
                if (cnt_reg == CNT_W'(NUM_MUL_OPS))
                begin
                    state_next = ST_DIVINIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DIVINIT:
            begin
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_FINISH;
                    kind_next  = OUT_FIELD;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // commands to the datapath
    always_comb
    begin
        cmd          = '0;
        cmd.rd_idx   = nb_t'(cnt_reg[2:0]);
        cmd.cap_idx  = nb_t'(cnt_reg[2:0] - 3'd1);
        cmd.mul_op   = cnt_reg[2:0];
        cmd.out_kind = kind_reg;
        req_ready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready    = 1'b1;
                cmd.load_wr  = req_valid && req_type == REQ_LOAD;
                cmd.latch    = req_valid && req_type == REQ_COMPUTE;
            end
            ST_CHECK:
            begin
                cmd.acc_clr = 1'b1;
            end
            ST_READ:
            begin
                cmd.rd_en  = cnt_reg < CNT_W'(NUM_READS);
                cmd.cap_en = cnt_reg != '0;
            end
            ST_MULT:
            begin
                cmd.mul_en = cnt_reg < CNT_W'(NUM_MUL_OPS);
            end
            ST_DIVINIT:
            begin
                cmd.div_init = 1'b1;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.out_load = slot_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // output slot occupancy
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            kind_reg      <= OUT_FIELD;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            kind_reg      <= kind_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // a compute transaction always starts with the grid check
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch |=> state_reg == ST_CHECK)
        else $error("compute transaction did not enter check");

    // a result never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!rsp_valid_reg || rsp_ready))
        else $error("result slot overwritten");

    // the last divider step leads to a field result
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == CNT_W'(DIV_STEPS - 1))
        |=> (state_reg == ST_FINISH && kind_reg == OUT_FIELD))
        else $error("divide sequence did not end in a field result");

    // a loaded result is shown in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (rsp_valid && state_reg == ST_IDLE))
        else $error("result not presented after load");

endmodule

/* design/dmifs_dp.sv */
`timescale 1ns / 1ps

module dmifs_dp import dmifs_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [SCALE_W-1:0]    cfg_data,
    input  req_t                  req_data,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    output rsp_t                  rsp_data
);

    // configuration registers
    logic [SCALE_W-1:0] scale_x_reg, scale_y_reg;
    logic               periodic_reg;
    logic [DIM_W-1:0]   width_used_reg, height_used_reg;

    // cell stores
    logic [VEC_W-1:0]   mag_mem [DEPTH];
    logic [MS_W-1:0]    sat_mem [DEPTH];
    logic [VEC_W-1:0]   mag_rd_reg;
    logic [MS_W-1:0]    sat_rd_reg;
    logic               miss_reg;

    logic [COORD_W-1:0] x_reg, y_reg;
    logic [DIM_W-1:0]   w_eff, h_eff;
    logic [COORD_W-1:0] nx, ny;
    logic               miss;

    logic [MS_W-1:0]    ms_reg;
    logic [VEC_W-1:0]   nb_reg [4];
    logic [VEC_W-1:0]   cap_vec;

    // multiplier stage
    logic signed [DIFF_W-1:0] d_sel;
    logic [DIFF_W-1:0]        d_abs;
    logic [SCALE_W-1:0]       s_sel, s_abs;
    logic [HALF_W-1:0]        half_op;
    logic [PP_W-1:0]          pp_next, pp_reg;
    logic                     pp_half_reg, pp_neg_reg, pp_vld_reg;
    logic [1:0]               tgt, pp_tgt_reg;
    logic [ACC_W-1:0]         term, sterm;
    logic signed [ACC_W-1:0]  acc_reg [NUM_LANES];

    // divider lanes
    logic [ACC_W-1:0]    s_mag   [NUM_LANES];
    logic [NUM_W-1:0]    numer   [NUM_LANES];
    logic                ovf     [NUM_LANES];
    logic [MS_W-1:0]     rem_reg [NUM_LANES];
    logic [FIELD_W-1:0]  quo_reg [NUM_LANES];
    logic                neg_reg [NUM_LANES];
    logic                ovf_reg [NUM_LANES];
    logic [MS_W:0]       trial   [NUM_LANES];
    logic                ge      [NUM_LANES];
    logic [MS_W-1:0]     rem_step[NUM_LANES];
    logic [FIELD_W-1:0]  fval    [NUM_LANES];
    logic                fsat    [NUM_LANES];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_x_reg     <= '0;
            scale_y_reg     <= '0;
            periodic_reg    <= 1'b0;
            width_used_reg  <= DIM_W'(MAX_WIDTH);
            height_used_reg <= DIM_W'(MAX_HEIGHT);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCALE_X:     scale_x_reg     <= cfg_data;
                CFG_SCALE_Y:     scale_y_reg     <= cfg_data;
                CFG_PERIODIC:    periodic_reg    <= cfg_data[0];
                CFG_WIDTH_USED:  width_used_reg  <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT_USED: height_used_reg <= cfg_data[DIM_W-1:0];
                default:         periodic_reg    <= periodic_reg;
            endcase
        end
    end

    // effective grid and range check
    always_comb
    begin
        w_eff = width_used_reg;
        if (width_used_reg == '0)
        begin
            w_eff = DIM_W'(1);
        end
        else if (width_used_reg > DIM_W'(MAX_WIDTH))
        begin
            w_eff = DIM_W'(MAX_WIDTH);
        end
        h_eff = height_used_reg;
        if (height_used_reg == '0)
        begin
            h_eff = DIM_W'(1);
        end
        else if (height_used_reg > DIM_W'(MAX_HEIGHT))
        begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end
    end

    assign sts.coord_err = ({1'b0, x_reg} >= w_eff) || ({1'b0, y_reg} >= h_eff);
    assign sts.ms_zero   = ms_reg == '0;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            x_reg <= req_data.cell_x;
            y_reg <= req_data.cell_y;
        end
    end

    // neighbor address with wrap or missing flag
    always_comb
    begin
        nx   = x_reg;
        ny   = y_reg;
        miss = 1'b0;
        case (cmd.rd_idx)
            NB_UP:
            begin
                if (y_reg == '0)
                begin
                    ny   = COORD_W'(h_eff - 1'b1);
                    miss = !periodic_reg;
                end
                else
                begin
                    ny = y_reg - 1'b1;
                end
            end
            NB_DOWN:
            begin
                if (({1'b0, y_reg} + 1'b1) >= h_eff)
                begin
                    ny   = '0;
                    miss = !periodic_reg;
                end
                else
                begin
                    ny = y_reg + 1'b1;
                end
            end
            NB_LEFT:
            begin
                if (x_reg == '0)
                begin
                    nx   = COORD_W'(w_eff - 1'b1);
                    miss = !periodic_reg;
                end
                else
                begin
                    nx = x_reg - 1'b1;
                end
            end
            NB_RIGHT:
            begin
                if (({1'b0, x_reg} + 1'b1) >= w_eff)
                begin
                    nx   = '0;
                    miss = !periodic_reg;
                end
                else
                begin
                    nx = x_reg + 1'b1;
                end
            end
            default:
            begin
                miss = 1'b0;
            end
        endcase
    end

    // store write on load
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
        begin
            mag_mem[{req_data.cell_y, req_data.cell_x}] <=
                {req_data.mag_z, req_data.mag_y, req_data.mag_x};
            sat_mem[{req_data.cell_y, req_data.cell_x}] <= req_data.sat_mag;
        end
    end

    // store read
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            mag_rd_reg <= mag_mem[{ny, nx}];
            sat_rd_reg <= sat_mem[{ny, nx}];
            miss_reg   <= miss;
        end
    end

    assign cap_vec = miss_reg ? '0 : mag_rd_reg;

    // capture center Ms and neighbor vectors
    always_ff @(posedge clk)
    begin
        if (cmd.cap_en)
        begin
            case (cmd.cap_idx)
                NB_CENTER: ms_reg    <= sat_rd_reg;
                NB_UP:     nb_reg[0] <= cap_vec;
                NB_DOWN:   nb_reg[1] <= cap_vec;
                NB_LEFT:   nb_reg[2] <= cap_vec;
                NB_RIGHT:  nb_reg[3] <= cap_vec;
                default:   ms_reg    <= ms_reg;
            endcase
        end
    end

    // operand select: difference and scale for one partial product
    always_comb
    begin
        case (cmd.mul_op[2:1])
            2'd0:
            begin
                d_sel = DIFF_W'($signed(nb_reg[0][3*MAG_W-1:2*MAG_W]))
                      - DIFF_W'($signed(nb_reg[1][3*MAG_W-1:2*MAG_W]));
                s_sel = scale_y_reg;
                tgt   = 2'd0;
            end
            2'd1:
            begin
                d_sel = DIFF_W'($signed(nb_reg[2][3*MAG_W-1:2*MAG_W]))
                      - DIFF_W'($signed(nb_reg[3][3*MAG_W-1:2*MAG_W]));
                s_sel = scale_x_reg;
                tgt   = 2'd1;
            end
            2'd2:
            begin
                d_sel = DIFF_W'($signed(nb_reg[1][MAG_W-1:0]))
                      - DIFF_W'($signed(nb_reg[0][MAG_W-1:0]));
                s_sel = scale_y_reg;
                tgt   = 2'd2;
            end
            default:
            begin
                d_sel = DIFF_W'($signed(nb_reg[3][2*MAG_W-1:MAG_W]))
                      - DIFF_W'($signed(nb_reg[2][2*MAG_W-1:MAG_W]));
                s_sel = scale_x_reg;
                tgt   = 2'd2;
            end
        endcase
        d_abs   = d_sel[DIFF_W-1] ? (~d_sel + 1'b1) : d_sel;
        s_abs   = s_sel[SCALE_W-1] ? (~s_sel + 1'b1) : s_sel;
        half_op = cmd.mul_op[0] ? s_abs[SCALE_W-1:HALF_W] : s_abs[HALF_W-1:0];
        pp_next = PP_W'(half_op) * PP_W'(d_abs[MAG_W-1:0]);
    end

    // partial product register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pp_vld_reg <= 1'b0;
        end
        else
        begin
            pp_vld_reg <= cmd.mul_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            pp_reg      <= pp_next;
            pp_half_reg <= cmd.mul_op[0];
            pp_neg_reg  <= d_sel[DIFF_W-1] ^ s_sel[SCALE_W-1];
            pp_tgt_reg  <= tgt;
        end
    end

    // signed accumulation into the three field sums
    always_comb
    begin
        if (pp_half_reg)
        begin
            term = {{(ACC_W-PP_W-HALF_W){1'b0}}, pp_reg, {HALF_W{1'b0}}};
        end
        else
        begin
            term = {{(ACC_W-PP_W){1'b0}}, pp_reg};
        end
        sterm = pp_neg_reg ? (~term + 1'b1) : term;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_LANES; k++)
        begin
            if (cmd.acc_clr)
            begin
                acc_reg[k] <= '0;
            end
            else if (pp_vld_reg && pp_tgt_reg == 2'(k))
            begin
                acc_reg[k] <= acc_reg[k] + $signed(sterm);
            end
        end
    end

    // divider lanes: magnitude >> 15, one quotient bit per step
    always_comb
    begin
        for (int k = 0; k < NUM_LANES; k++)
        begin
            s_mag[k]    = acc_reg[k][ACC_W-1] ? (~acc_reg[k] + 1'b1) : acc_reg[k];
            numer[k]    = s_mag[k][ACC_W-2:15];
            ovf[k]      = {{(MS_W-(NUM_W-FIELD_W)){1'b0}}, numer[k][NUM_W-1:FIELD_W]}
                          >= ms_reg;
            trial[k]    = {rem_reg[k], quo_reg[k][FIELD_W-1]};
            ge[k]       = trial[k] >= {1'b0, ms_reg};
            rem_step[k] = ge[k] ? MS_W'(trial[k] - {1'b0, ms_reg}) : trial[k][MS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_LANES; k++)
        begin
            if (cmd.div_init)
            begin
                rem_reg[k] <= MS_W'(numer[k][NUM_W-1:FIELD_W]);
                quo_reg[k] <= numer[k][FIELD_W-1:0];
                neg_reg[k] <= acc_reg[k][ACC_W-1];
                ovf_reg[k] <= ovf[k];
            end
            else if (cmd.div_step)
            begin
                rem_reg[k] <= rem_step[k];
                quo_reg[k] <= {quo_reg[k][FIELD_W-2:0], ge[k]};
            end
        end
    end

    // sign and clip
    always_comb
    begin
        for (int k = 0; k < NUM_LANES; k++)
        begin
            if (neg_reg[k])
            begin
                fsat[k] = ovf_reg[k] || (quo_reg[k] > {1'b1, {(FIELD_W-1){1'b0}}});
                fval[k] = fsat[k] ? {1'b1, {(FIELD_W-1){1'b0}}} : (~quo_reg[k] + 1'b1);
            end
            else
            begin
                fsat[k] = ovf_reg[k] || quo_reg[k][FIELD_W-1];
                fval[k] = fsat[k] ? {1'b0, {(FIELD_W-1){1'b1}}} : quo_reg[k];
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            case (cmd.out_kind)
                OUT_FIELD:
                begin
                    rsp_data.field_x     <= fval[0];
                    rsp_data.field_y     <= fval[1];
                    rsp_data.field_z     <= fval[2];
                    rsp_data.saturated   <= fsat[0] || fsat[1] || fsat[2];
                    rsp_data.coord_error <= 1'b0;
                end
                OUT_ERROR:
                begin
                    rsp_data.field_x     <= '0;
                    rsp_data.field_y     <= '0;
                    rsp_data.field_z     <= '0;
                    rsp_data.saturated   <= 1'b0;
                    rsp_data.coord_error <= 1'b1;
                end
                default:
                begin
                    rsp_data <= '0;
                end
            endcase
        end
    end

endmodule

/* design/dmi_d2d_field_stencil_core.sv */
`timescale 1ns / 1ps

// D2d DMI effective-field stencil for one 64x64 magnetisation slice. A load
// transaction writes a cell's Q1.15 unit vector and Ms into the on-chip stores
// and returns nothing. A compute transaction returns one result: it reads the
// cell and its four x/y neighbors (zero or wrapped at the edges), forms the
// scaled differences, divides each sum by Ms * 2^15 with truncation and clips
// to 32 bits. A compute passes in order through the grid check, the store
// reads on the single read port, the eight 24x16 partial products of the
// shared multiplier, the three radix-2 divider lanes running side by side,
// and the load of the output register. Out-of-grid cells answer after the
// grid check and cells with Ms zero after the store reads.
// One transaction is worked at a time; the next is taken while a result still
// waits in the output register.
// Store entries must be loaded before they are read.

module dmi_d2d_field_stencil_core import dmifs_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [SCALE_W-1:0]    cfg_data,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req_data,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp_data
);

    cmd_t cmd;
    sts_t sts;

    // sequencing
    dmifs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_type  (req_data.req_type),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // stores, multiplier and dividers
    dmifs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_data  (req_data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_data  (rsp_data)
    );

endmodule

/* sim/dmi_d2d_field_stencil_core_tb.sv */
`timescale 1ns / 1ps

module dmi_d2d_field_stencil_core_tb;
    import dmifs_pkg::*;

    // --------------------------------------------------------------
    // expected-field scoreboard with its own copy of stores and registers
    // --------------------------------------------------------------
    class dmi_field_board;
        logic signed [SCALE_W-1:0] kx;
        logic signed [SCALE_W-1:0] ky;
        bit                        wrap;
        logic [DIM_W-1:0]          w_used;
        logic [DIM_W-1:0]          h_used;
        logic [VEC_W-1:0]          vec_mem [DEPTH];
        logic [MS_W-1:0]           ms_mem [DEPTH];
        rsp_t                      pending [$];
        int                        errors;

        function void init();
            kx = '0;
            ky = '0;
            wrap = 0;
            w_used = DIM_W'(MAX_WIDTH);
            h_used = DIM_W'(MAX_HEIGHT);
            errors = 0;
            foreach (vec_mem[i])
            begin
                vec_mem[i] = '0;
                ms_mem[i] = '0;
            end
        endfunction

        function void set_reg(cfg_idx_t idx, logic [SCALE_W-1:0] v);
            case (idx)
                CFG_SCALE_X:     kx = v;
                CFG_SCALE_Y:     ky = v;
                CFG_PERIODIC:    wrap = v[0];
                CFG_WIDTH_USED:  w_used = v[DIM_W-1:0];
                CFG_HEIGHT_USED: h_used = v[DIM_W-1:0];
                default: ;
            endcase
        endfunction

        // one magnetisation component of a neighbor, zero when off-grid
        function longint comp(int x, int y, int w, int h, int c);
            logic [VEC_W-1:0] v;
            if (wrap)
            begin
                x = (x + w) % w;
                y = (y + h) % h;
            end
            else if (x < 0 || y < 0 || x >= w || y >= h)
                return 0;
            v = vec_mem[y * MAX_WIDTH + x];
            return longint'($signed(v[c*MAG_W +: MAG_W]));
        endfunction

        // truncating division by Ms*2^15 and clip to 32 bits
        function logic [FIELD_W-1:0] div_clip(logic signed [69:0] s, longint dv, ref bit sat);
            logic signed [69:0] q;
            q = s / $signed({6'd0, 64'(dv)});
            if (q > 70'sd2147483647)
            begin
                sat = 1;
                q = 70'sd2147483647;
            end
            else if (q < -70'sd2147483648)
            begin
                sat = 1;
                q = -70'sd2147483648;
            end
            return q[FIELD_W-1:0];
        endfunction

        // note an accepted input transaction
        function void note_req(req_t r);
            int x, y, w, h;
            longint ms;
            logic signed [69:0] sx, sy, sz;
            bit sat;
            rsp_t e;
            x = r.cell_x;
            y = r.cell_y;
            if (r.req_type == REQ_LOAD)
            begin
                vec_mem[y*MAX_WIDTH+x] = {r.mag_z, r.mag_y, r.mag_x};
                ms_mem[y*MAX_WIDTH+x] = r.sat_mag;
                return;
            end
            w = (w_used < 1) ? 1 : (w_used > MAX_WIDTH ? MAX_WIDTH : w_used);
            h = (h_used < 1) ? 1 : (h_used > MAX_HEIGHT ? MAX_HEIGHT : h_used);
            e = '0;
            sat = 0;
            if (x >= w || y >= h)
                e.coord_error = 1;
            else
            begin
                ms = ms_mem[y*MAX_WIDTH+x];
                if (ms != 0)
                begin
                    sx = 70'(ky) * 70'(comp(x, y-1, w, h, 2) - comp(x, y+1, w, h, 2));
                    sy = 70'(kx) * 70'(comp(x-1, y, w, h, 2) - comp(x+1, y, w, h, 2));
                    sz = 70'(ky) * 70'(comp(x, y+1, w, h, 0) - comp(x, y-1, w, h, 0))
                       + 70'(kx) * 70'(comp(x+1, y, w, h, 1) - comp(x-1, y, w, h, 1));
                    e.field_x = div_clip(sx, ms << 15, sat);
                    e.field_y = div_clip(sy, ms << 15, sat);
                    e.field_z = div_clip(sz, ms << 15, sat);
                    e.saturated = sat;
                end
            end
            pending.push_back(e);
        endfunction

        // check one accepted result transaction
        function void check_rsp(rsp_t a);
            rsp_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result transaction %h", a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.field_x !== e.field_x)
            begin
                $error("field_x expected %0d actual %0d", e.field_x, a.field_x);
                errors++;
            end
            if (a.field_y !== e.field_y)
            begin
                $error("field_y expected %0d actual %0d", e.field_y, a.field_y);
                errors++;
            end
            if (a.field_z !== e.field_z)
            begin
                $error("field_z expected %0d actual %0d", e.field_z, a.field_z);
                errors++;
            end
            if (a.saturated !== e.saturated)
            begin
                $error("saturated expected %0d actual %0d", e.saturated, a.saturated);
                errors++;
            end
            if (a.coord_error !== e.coord_error)
            begin
                $error("coord_error expected %0d actual %0d", e.coord_error, a.coord_error);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SCALE_W-1:0]   cfg_data;
    logic                 req_valid;
    logic                 req_ready;
    req_t                 req_data;
    logic                 rsp_valid;
    logic                 rsp_ready;
    rsp_t                 rsp_data;

    dmi_field_board board;
    int             gap_left;
    int             stall_mode;

    dmi_d2d_field_stencil_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    // clock
    initial clk = 0;
    always #4 clk = ~clk;

    // receiver stall pattern and result check
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            board.check_rsp(rsp_data);
        case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= ($urandom_range(0, 9) > 6);
        endcase
    end

    // overall time limit
    initial
    begin
        #40ms;
        $display("Test completed with failures");
        $finish;
    end

    // send one request transaction, in bursts with random gaps
    task automatic send_req(req_t r);
        if (gap_left == 0 && $urandom_range(0, 7) == 0)
            gap_left = $urandom_range(1, 80);
        while (gap_left > 0)
        begin
            @(posedge clk);
            req_valid <= 1'b0;
            gap_left--;
        end
        @(posedge clk);
        req_valid <= 1'b1;
        req_data <= r;
        do
            @(posedge clk);
        while (!req_ready);
        board.note_req(r);
        req_valid <= 1'b0;
    endtask

    // wait until idle, then write a register
    task automatic write_reg(cfg_idx_t idx, logic [SCALE_W-1:0] v);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        board.set_reg(idx, v);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_cell(int x, int y, bit rnd_ms, bit extreme);
        req_t r;
        r = '0;
        r.req_type = REQ_LOAD;
        r.cell_x = COORD_W'(x);
        r.cell_y = COORD_W'(y);
        r.mag_x = extreme ? 16'h8000 : 16'($urandom);
        r.mag_y = extreme ? 16'h7fff : 16'($urandom);
        r.mag_z = extreme ? 16'h8000 : 16'($urandom);
        case ($urandom_range(0, 5))
            0: r.sat_mag = '0;
            1: r.sat_mag = MS_W'(1);
            2: r.sat_mag = 22'h3fffff;
            default: r.sat_mag = MS_W'($urandom_range(1, 4194303) >> $urandom_range(0, 21));
        endcase
        if (!rnd_ms)
            r.sat_mag = MS_W'(1);
        send_req(r);
    endtask

    // compute only where every cell that could be read has been loaded
    task automatic compute_cell(int x, int y);
        req_t r;
        r = '0;
        r.req_type = REQ_COMPUTE;
        r.cell_x = COORD_W'(x);
        r.cell_y = COORD_W'(y);
        r.mag_x = 16'($urandom);
        r.mag_y = 16'($urandom);
        r.mag_z = 16'($urandom);
        r.sat_mag = MS_W'($urandom);
        send_req(r);
    endtask

    // set up and load a whole w x h grid, then random computes, about one in ten anywhere on 64x64
    task automatic run_phase(int w, int h, bit per, int n_comp);
        write_reg(CFG_WIDTH_USED, SCALE_W'(w));
        write_reg(CFG_HEIGHT_USED, SCALE_W'(h));
        write_reg(CFG_PERIODIC, SCALE_W'(per));
        for (int y = 0; y < h && y < MAX_HEIGHT; y++)
            for (int x = 0; x < w && x < MAX_WIDTH; x++)
                load_cell(x, y, 1, 0);
        for (int i = 0; i < n_comp; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                compute_cell($urandom_range(0, 63), $urandom_range(0, 63));
            else
                compute_cell($urandom_range(0, w-1), $urandom_range(0, h-1));
        end
    endtask

    function automatic logic [SCALE_W-1:0] rand_scale();
        case ($urandom_range(0, 4))
            0: return 48'h800000000000;
            1: return 48'h7fffffffffff;
            2: return SCALE_W'({$urandom, $urandom} >> $urandom_range(0, 40));
            default: return {16'($urandom), $urandom};
        endcase
    endfunction

    initial
    begin
        board = new();
        board.init();
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        req_valid = 0;
        req_data = '0;
        rsp_ready = 0;
        gap_left = 0;
        stall_mode = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme values on a tiny grid
        write_reg(CFG_SCALE_X, 48'h7fffffffffff);
        write_reg(CFG_SCALE_Y, 48'h800000000000);
        write_reg(CFG_WIDTH_USED, SCALE_W'(2));
        write_reg(CFG_HEIGHT_USED, SCALE_W'(2));
        write_reg(CFG_PERIODIC, SCALE_W'(0));
        load_cell(0, 0, 0, 1);
        load_cell(1, 0, 0, 0);
        load_cell(0, 1, 0, 1);
        load_cell(1, 1, 0, 0);
        compute_cell(0, 0);
        compute_cell(1, 1);
        compute_cell(1, 0);
        compute_cell(2, 0);
        compute_cell(63, 63);
        write_reg(CFG_PERIODIC, SCALE_W'(1));
        compute_cell(0, 1);
        // single cell periodic, and an Ms of zero
        write_reg(CFG_WIDTH_USED, SCALE_W'(1));
        write_reg(CFG_HEIGHT_USED, SCALE_W'(1));
        compute_cell(0, 0);
        load_cell(63, 63, 0, 1);
        begin
            req_t r;
            r = '0;
            r.req_type = REQ_LOAD;
            r.mag_x = 16'h7fff;
            send_req(r);
        end
        compute_cell(0, 0);
        // out-of-range register values clamp, open edges
        write_reg(CFG_PERIODIC, SCALE_W'(0));
        write_reg(CFG_WIDTH_USED, SCALE_W'(0));
        write_reg(CFG_HEIGHT_USED, SCALE_W'(127));
        compute_cell(0, 0);
        compute_cell(1, 0);

        // random phases over several settings
        for (int p = 0; p < 8; p++)
        begin
            stall_mode = p % 3;
            write_reg(CFG_SCALE_X, rand_scale());
            write_reg(CFG_SCALE_Y, rand_scale());
            case (p)
                0: run_phase(1, 9, 1, 20);
                1: run_phase(7, 1, 0, 20);
                2: run_phase(5, 4, 1, 25);
                3: run_phase(6, 5, 0, 25);
                4: run_phase(3, 3, 1, 25);
                5: run_phase(64, 1, $urandom_range(0, 1), 20);
                6: run_phase(1, 64, $urandom_range(0, 1), 20);
                default: run_phase($urandom_range(2, 8), $urandom_range(2, 8), 0, 25);
            endcase
        end

        // drain
        stall_mode = 0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
